// ----- src/gmq_pkg.sv -----
// ----------------------------------------------------------------------------
// gmq_pkg
// Shared types, constants and GF(16) arithmetic for the GF(16) MQ public map
// evaluator.
// ----------------------------------------------------------------------------
package gmq_pkg;

   localparam int DEF_MAX_VARS = 96;
   localparam int DEF_NUM_EQS  = 64;

   localparam int GF_W       = 4;
   localparam int WORD_W     = 64;
   localparam int WORD_NIBS  = WORD_W / GF_W;
   localparam int RESULT_W   = 4 * WORD_W;

   localparam int VAR_COUNT_W = 7;
   localparam int FIELD_POLY_W = 5;
   localparam int CSR_DATA_W  = 7;
   localparam int PTR_W       = 3;
   // var_count (7 bits) and the largest variable count both fit in 8 bits
   localparam int CMP_W       = 8;

   localparam logic [VAR_COUNT_W-1:0]  VAR_COUNT_RESET  = 7'd96;
   localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RESET = 5'd19;

   typedef enum logic [0:0] {
      CSR_VAR_COUNT  = 1'b0,
      CSR_FIELD_POLY = 1'b1
   } csr_idx_type;

   typedef enum logic [0:0] {
      OP_VAR_WORD = 1'b0,
      OP_KEY_ROW  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      PH_LINEAR,
      PH_QUAD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      K_CLEAR,
      K_LINEAR,
      K_QUAD
   } kind_type;

   typedef struct packed {
      logic            en;
      logic            clear;
      logic [GF_W-1:0] factor;
      logic [GF_W-1:0] poly;
   } lane_ctl_type;

   // shift-and-add multiply, reduced by the low four bits of the polynomial
   function automatic logic [GF_W-1:0] gf_mul(input logic [GF_W-1:0] a,
                                              input logic [GF_W-1:0] b,
                                              input logic [GF_W-1:0] poly);
      logic [GF_W-1:0] r;
      logic [GF_W-1:0] s;
      logic            c;
      r = '0;
      s = a;
      for (int k = 0; k < GF_W; k++) begin
         if (b[k]) r = r ^ s;
         c = s[GF_W-1];
         s = {s[GF_W-2:0], 1'b0};
         if (c) s = s ^ poly;
      end
      return r;
   endfunction

endpackage

// ----- src/gmq_var_mem.sv -----
// ----------------------------------------------------------------------------
// gmq_var_mem
// Variable store: rows of 16 nibble variables, one write port and two
// registered read ports (outer and inner variable of a row).
// ----------------------------------------------------------------------------
module gmq_var_mem #(
   parameter int MAX_VARS = gmq_pkg::DEF_MAX_VARS
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [gmq_pkg::PTR_W-1:0]             wr_row,
   input  logic [gmq_pkg::WORD_W-1:0]            wr_data,
   input  logic                                  rd_en,
   input  logic [$clog2(MAX_VARS)-1:0]           rd_addr_o,
   input  logic [$clog2(MAX_VARS)-1:0]           rd_addr_i,
   output logic [gmq_pkg::WORD_W-1:0]            rd_word_o,
   output logic [gmq_pkg::WORD_W-1:0]            rd_word_i
);
   import gmq_pkg::*;

   localparam int VAR_ROWS = (MAX_VARS + WORD_NIBS - 1) / WORD_NIBS;
   localparam int ROW_W    = (VAR_ROWS > 1) ? $clog2(VAR_ROWS) : 1;

   logic [WORD_W-1:0] mem [VAR_ROWS];
   logic [WORD_W-1:0] rd_word_o_ff;
   logic [WORD_W-1:0] rd_word_i_ff;

   always_ff @(posedge clock) begin
      // rows past the store are dropped
      if (wr_en && (int'(wr_row) < VAR_ROWS)) begin
         mem[ROW_W'(wr_row)] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_o_ff <= mem[ROW_W'(rd_addr_o >> 4)];
         rd_word_i_ff <= mem[ROW_W'(rd_addr_i >> 4)];
      end
   end

   assign rd_word_o = rd_word_o_ff;
   assign rd_word_i = rd_word_i_ff;

endmodule

// ----- src/gmq_lane.sv -----
// ----------------------------------------------------------------------------
// gmq_lane
// One equation lane: multiplies its coefficient by the row factor and folds
// the product into its nibble accumulator.
// ----------------------------------------------------------------------------
module gmq_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  gmq_pkg::lane_ctl_type      ctl,
   input  logic [gmq_pkg::GF_W-1:0]   coef,
   output logic [gmq_pkg::GF_W-1:0]   acc_next
);
   import gmq_pkg::*;

   logic [GF_W-1:0] acc_ff;
   logic [GF_W-1:0] acc_in;

   always_comb begin
      if (ctl.clear) begin
         acc_in = '0;
      end else begin
         acc_in = acc_ff ^ gf_mul(coef, ctl.factor, ctl.poly);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_next = acc_in;

endmodule

// ----- src/gmq_merge.sv -----
// ----------------------------------------------------------------------------
// gmq_merge
// Merge stage: gathers the lane accumulators into the result register and
// holds it until the result transaction completes.
// ----------------------------------------------------------------------------
module gmq_merge #(
   parameter int NUM_EQS = gmq_pkg::DEF_NUM_EQS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [NUM_EQS*gmq_pkg::GF_W-1:0]  acc_vec,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [gmq_pkg::RESULT_W-1:0]      result,
   output logic                              out_free
);
   import gmq_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic [NUM_EQS*GF_W-1:0]   result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= acc_vec;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = RESULT_W'(result_ff);
   assign out_free  = !valid_ff || !rsp_stall;

endmodule

// ----- src/gf16_mq_public_map_eval_core.sv -----
// ----------------------------------------------------------------------------
// gf16_mq_public_map_eval_core
// Evaluates NUM_EQS quadratic polynomials over GF(16) at up to MAX_VARS
// nibble variables, one variable word or key row per transaction.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------
//   req     | req_valid | req_stall | opcode, start_req, data_a .. data_d
//   rsp     | rsp_valid | rsp_stall | result_a .. result_d
//   csr     | csr_we    | -         | csr_index, csr_wdata
//
// One transaction per cycle while req_stall is low. Pipeline: row control and
// variable store read, factor product, lane multiply-accumulate into the
// result register; the result of the last quadratic row passes stage 1 and
// stage 2 before it is loaded into the result register. req_stall rises only
// while a finished result sits in the last stage behind a full, stalled
// result register. Reset is synchronous; the variable store is not cleared.
// ----------------------------------------------------------------------------
module gf16_mq_public_map_eval_core #(
   parameter int MAX_VARS = gmq_pkg::DEF_MAX_VARS,
   parameter int NUM_EQS  = gmq_pkg::DEF_NUM_EQS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic                               req_start_req,
   input  logic [gmq_pkg::WORD_W-1:0]         req_data_a,
   input  logic [gmq_pkg::WORD_W-1:0]         req_data_b,
   input  logic [gmq_pkg::WORD_W-1:0]         req_data_c,
   input  logic [gmq_pkg::WORD_W-1:0]         req_data_d,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gmq_pkg::WORD_W-1:0]         rsp_result_a,
   output logic [gmq_pkg::WORD_W-1:0]         rsp_result_b,
   output logic [gmq_pkg::WORD_W-1:0]         rsp_result_c,
   output logic [gmq_pkg::WORD_W-1:0]         rsp_result_d,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [gmq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gmq_pkg::*;

   localparam int IDX_W  = $clog2(MAX_VARS);
   localparam int CNT_W  = $clog2(MAX_VARS + 1);
   localparam int COEF_W = NUM_EQS * GF_W;

   // configuration
   logic [VAR_COUNT_W-1:0]  var_count_ff;
   logic [FIELD_POLY_W-1:0] field_poly_ff;

   // row control
   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    row_outer_ff, row_outer_in;
   logic [CNT_W-1:0]    row_inner_ff, row_inner_in;
   logic [PTR_W-1:0]    load_ptr_ff, load_ptr_in;

   logic                adv;
   logic                req_acc;
   logic [CMP_W-1:0]    n_active;
   logic [CMP_W-1:0]    outer_next;
   logic [PTR_W-1:0]    ptr_base;
   logic                mem_we;
   logic                issue_valid;
   kind_type            issue_kind;
   logic                issue_emit;

   // stage 1
   logic                s1_valid_ff;
   kind_type            s1_kind_ff;
   logic                s1_emit_ff;
   logic [COEF_W-1:0]   s1_coef_ff;
   logic [3:0]          s1_nib_o_ff;
   logic [3:0]          s1_nib_i_ff;
   logic [WORD_W-1:0]   rd_word_o;
   logic [WORD_W-1:0]   rd_word_i;
   logic [GF_W-1:0]     x_o;
   logic [GF_W-1:0]     x_i;
   logic [GF_W-1:0]     factor;

   // stage 2
   logic                s2_valid_ff;
   logic                s2_clear_ff;
   logic                s2_emit_ff;
   logic [GF_W-1:0]     s2_factor_ff;
   logic [COEF_W-1:0]   s2_coef_ff;

   lane_ctl_type        lane_ctl;
   logic [COEF_W-1:0]   acc_vec;
   logic                out_free;
   logic [RESULT_W-1:0] result;
   logic [RESULT_W-1:0] coef_all;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff  <= VAR_COUNT_RESET;
         field_poly_ff <= FIELD_POLY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VAR_COUNT:  var_count_ff  <= csr_wdata[VAR_COUNT_W-1:0];
            CSR_FIELD_POLY: field_poly_ff <= csr_wdata[FIELD_POLY_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the whole pipeline only when a result must wait for the output
   assign adv       = !(s2_valid_ff && s2_emit_ff) || out_free;
   assign req_stall = !adv;
   assign req_acc   = req_valid && adv;

   always_comb begin
      if (var_count_ff == '0) begin
         n_active = CMP_W'(1);
      end else if (CMP_W'(var_count_ff) > CMP_W'(MAX_VARS)) begin
         n_active = CMP_W'(MAX_VARS);
      end else begin
         n_active = CMP_W'(var_count_ff);
      end
   end

   assign outer_next = CMP_W'(row_outer_ff) + CMP_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      row_outer_in = row_outer_ff;
      row_inner_in = row_inner_ff;
      load_ptr_in  = load_ptr_ff;
      ptr_base     = load_ptr_ff;
      mem_we       = 1'b0;
      issue_valid  = 1'b0;
      issue_kind   = K_LINEAR;
      issue_emit   = 1'b0;
      if (req_acc) begin
         if (req_opcode == OP_VAR_WORD) begin
            if (req_start_req) begin
               ptr_base     = '0;
               phase_in     = PH_LINEAR;
               row_outer_in = '0;
               row_inner_in = '0;
               // clear the lane accumulators in order with the rows
               issue_valid  = 1'b1;
               issue_kind   = K_CLEAR;
            end
            mem_we      = 1'b1;
            load_ptr_in = ptr_base + PTR_W'(1);
         end else begin
            case (phase_ff)
               PH_LINEAR: begin
                  issue_valid = 1'b1;
                  issue_kind  = K_LINEAR;
                  if (outer_next >= n_active) begin
                     phase_in     = PH_QUAD;
                     row_outer_in = '0;
                     row_inner_in = '0;
                  end else begin
                     row_outer_in = CNT_W'(outer_next);
                  end
               end
               PH_QUAD: begin
                  issue_valid = 1'b1;
                  issue_kind  = K_QUAD;
                  if (row_inner_ff >= row_outer_ff) begin
                     row_inner_in = '0;
                     if (outer_next >= n_active) begin
                        phase_in     = PH_DONE;
                        row_outer_in = '0;
                        issue_emit   = 1'b1;
                     end else begin
                        row_outer_in = CNT_W'(outer_next);
                     end
                  end else begin
                     row_inner_in = row_inner_ff + CNT_W'(1);
                  end
               end
               default: ;  // rows after the result are dropped
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINEAR;
         row_outer_ff <= '0;
         row_inner_ff <= '0;
         load_ptr_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         row_outer_ff <= row_outer_in;
         row_inner_ff <= row_inner_in;
         load_ptr_ff  <= load_ptr_in;
      end
   end

   gmq_var_mem #(
      .MAX_VARS (MAX_VARS)
   ) u_var_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_row    (ptr_base),
      .wr_data   (req_data_a),
      .rd_en     (adv),
      .rd_addr_o (row_outer_ff[IDX_W-1:0]),
      .rd_addr_i (row_inner_ff[IDX_W-1:0]),
      .rd_word_o (rd_word_o),
      .rd_word_i (rd_word_i)
   );

   assign coef_all = {req_data_d, req_data_c, req_data_b, req_data_a};

   // stage 1: coefficients and nibble positions ride along with the read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= issue_kind;
         s1_emit_ff  <= issue_emit;
         s1_coef_ff  <= coef_all[COEF_W-1:0];
         s1_nib_o_ff <= row_outer_ff[3:0];
         s1_nib_i_ff <= row_inner_ff[3:0];
      end
   end

   assign x_o = rd_word_o[s1_nib_o_ff*GF_W +: GF_W];
   assign x_i = rd_word_i[s1_nib_i_ff*GF_W +: GF_W];

   always_comb begin
      if (s1_kind_ff == K_QUAD) begin
         factor = gf_mul(x_o, x_i, field_poly_ff[GF_W-1:0]);
      end else begin
         factor = x_o;
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_clear_ff  <= (s1_kind_ff == K_CLEAR);
         s2_emit_ff   <= s1_emit_ff;
         s2_factor_ff <= factor;
         s2_coef_ff   <= s1_coef_ff;
      end
   end

   assign lane_ctl.en     = adv && s2_valid_ff;
   assign lane_ctl.clear  = s2_clear_ff;
   assign lane_ctl.factor = s2_factor_ff;
   assign lane_ctl.poly   = field_poly_ff[GF_W-1:0];

   for (genvar e = 0; e < NUM_EQS; e++) begin : g_lane
      gmq_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .coef     (s2_coef_ff[e*GF_W +: GF_W]),
         .acc_next (acc_vec[e*GF_W +: GF_W])
      );
   end

   gmq_merge #(
      .NUM_EQS (NUM_EQS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (adv && s2_valid_ff && s2_emit_ff),
      .acc_vec   (acc_vec),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .result    (result),
      .out_free  (out_free)
   );

   assign rsp_result_a = result[0*WORD_W +: WORD_W];
   assign rsp_result_b = result[1*WORD_W +: WORD_W];
   assign rsp_result_c = result[2*WORD_W +: WORD_W];
   assign rsp_result_d = result[3*WORD_W +: WORD_W];

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff && s2_emit_ff) |=> rsp_valid)
      else $error("finished result did not reach the result register");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s2_valid_ff && s2_emit_ff && rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");

   a_linear_inner_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LINEAR) |-> (row_inner_ff == '0))
      else $error("inner row position moved during linear rows");

   a_quad_triangle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_QUAD) |-> (row_inner_ff <= row_outer_ff))
      else $error("inner row position passed outer row position");

endmodule
